// ===== rtl/core/mvsm_pkg.sv =====
// ----------------------------------------------------------------------------
// mvsm_pkg
// shared types, codes and defaults of the four-voice sample mixer
// ----------------------------------------------------------------------------
package mvsm_pkg;

  // default sizes
  localparam int VOICE_COUNT_DEF  = 4;
  localparam int SOUND_COUNT_DEF  = 3;
  localparam int SOUND_DEPTH_DEF  = 4096;
  localparam int BLOCK_FRAMES_DEF = 64;

  // field widths
  localparam int OPCODE_W  = 2;
  localparam int SND_SEL_W = 2;
  localparam int SAMPLE_ADDR_W = 12;
  localparam int SAMPLE_W  = 16;
  localparam int LENGTH_W  = 13;
  localparam int GAIN_W    = 15;

  // configuration port
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;
  localparam int LENGTH_REGS = 3;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd9830;

  // mixing
  localparam int GAIN_SHIFT  = 15;
  localparam int SAT_LIMIT   = 32767;
  localparam int DIGIT_W     = 4;
  localparam int GAIN_DIGITS = (GAIN_W + DIGIT_W - 1) / DIGIT_W;
  localparam int GAIN_SR_W   = GAIN_DIGITS * DIGIT_W;
  localparam int PROD_W      = 2 * SAMPLE_W;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TRIGGER = 2'd0,
    OP_LOAD    = 2'd1,
    OP_FRAME   = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    REG_LEN_A = 2'd0,
    REG_LEN_B = 2'd1,
    REG_LEN_C = 2'd2,
    REG_GAIN  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [OPCODE_W-1:0]        opcode;
    logic [SND_SEL_W-1:0]       snd_sel;
    logic [SAMPLE_ADDR_W-1:0]   sample_address;
    logic signed [SAMPLE_W-1:0] sample_word;
  } cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mixed_sample;
    logic                       block_end;
  } mix_t;

endpackage

// ===== rtl/core/multi_voice_sample_mixer.sv =====
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer
// sound-effect mixer: sample store, voice allocation and a digit-serial mix
// ----------------------------------------------------------------------------
// cmd beats carry one of three operations. a trigger marks a sound pending and
// a load writes one word of the sample store; neither gives a mix beat. a frame
// beat renders one mono sample and gives exactly one mix beat, with block_end
// set on the last frame of each block.
// on the first frame of a block the pending sounds are started in id order,
// one per cycle, in S_START. the voices are then visited in turn: an idle
// voice is skipped in S_READ, a busy one passes through S_READ (memory read),
// S_MUL (one 4-bit gain digit per cycle) and S_ACC (accumulate), all through
// the single read port of the sample memory. S_OUT then loads the output
// register. cmd_ready is high only between frames; a finished mix beat may
// wait in its register while the next cmd beat is taken, and a stalled mix
// receiver holds the following frame in its last step.
// reset clears the voices, pending flags and frame count, sets the lengths to
// zero and the gain to about 0.3; the sample store is not cleared and must be
// loaded before a sound that reads it is triggered.
// ----------------------------------------------------------------------------
module multi_voice_sample_mixer #(
  parameter int VOICE_COUNT  = mvsm_pkg::VOICE_COUNT_DEF,
  parameter int SOUND_COUNT  = mvsm_pkg::SOUND_COUNT_DEF,
  parameter int SOUND_DEPTH  = mvsm_pkg::SOUND_DEPTH_DEF,
  parameter int BLOCK_FRAMES = mvsm_pkg::BLOCK_FRAMES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  mvsm_pkg::cmd_t              cmd,
  output logic                        mix_valid,
  input  logic                        mix_ready,
  output mvsm_pkg::mix_t              mix,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mvsm_pkg::CFG_AW-1:0] paddr,
  input  logic [mvsm_pkg::CFG_DW-1:0] pwdata,
  output logic [mvsm_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import mvsm_pkg::*;

  localparam int VID_W   = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int SID_W   = (SOUND_COUNT > 1) ? $clog2(SOUND_COUNT) : 1;
  localparam int POS_W   = $clog2(SOUND_DEPTH + 1);
  localparam int FR_W    = (BLOCK_FRAMES > 1) ? $clog2(BLOCK_FRAMES) : 1;
  localparam int MEM_D   = SOUND_COUNT * SOUND_DEPTH;
  localparam int MEM_AW  = $clog2(MEM_D);
  localparam int DCNT_W  = (GAIN_DIGITS > 1) ? $clog2(GAIN_DIGITS) : 1;
  localparam int ACC_W   = PROD_W + VID_W;
  localparam int PART_W  = SAMPLE_W + DIGIT_W + 1;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(SAT_LIMIT);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,
    S_READ  = 6'b000100,
    S_MUL   = 6'b001000,
    S_ACC   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [SAMPLE_W-1:0]  sample_store [MEM_D];
  logic [SAMPLE_W-1:0]  rd_data;
  logic [MEM_AW-1:0]    rd_addr, wr_addr;
  logic                 rd_en, load_en;

  logic                 voice_busy [VOICE_COUNT];
  logic [SID_W-1:0]     voice_sound [VOICE_COUNT];
  logic [POS_W-1:0]     voice_position [VOICE_COUNT];
  logic [SOUND_COUNT-1:0] pending_flags;
  logic [FR_W-1:0]      frame_in_block;

  logic [LENGTH_W-1:0]  length_a, length_b, length_c;
  logic [GAIN_W-1:0]    voice_gain;

  logic [SID_W-1:0]     sidx;
  logic [VID_W-1:0]     vidx;
  logic [DCNT_W-1:0]    dcnt;
  logic [GAIN_SR_W-1:0] gain_sr;
  logic signed [PROD_W-1:0] prod, prod_next;
  logic signed [PART_W-1:0] part;
  logic signed [ACC_W-1:0]  acc, shifted;
  logic signed [SAMPLE_W-1:0] sat;

  logic                 accept, cfg_write, cmd_sid_ok, last_voice, last_frame;
  logic                 out_free;
  logic [VID_W-1:0]     slot;
  logic [LENGTH_W-1:0]  raw_len;
  logic [POS_W-1:0]     cur_len, pos_inc;
  logic [DIGIT_W-1:0]   digit;

  assign accept     = cmd_valid && cmd_ready;
  assign cmd_ready  = (state == S_IDLE);
  assign cfg_write  = psel && penable && pwrite && pready;
  assign pready     = 1'b1;
  assign cmd_sid_ok = (32'(cmd.snd_sel) < SOUND_COUNT);
  assign last_voice = (vidx == VID_W'(VOICE_COUNT - 1));
  assign last_frame = (32'(frame_in_block) + 32'd1 >= BLOCK_FRAMES);
  assign out_free   = !mix_valid || mix_ready;

  // sample store
  assign load_en = accept && (cmd.opcode == OP_LOAD) && cmd_sid_ok
                   && (32'(cmd.sample_address) < SOUND_DEPTH);
  assign wr_addr = MEM_AW'(32'(cmd.snd_sel) * SOUND_DEPTH + 32'(cmd.sample_address));
  assign rd_en   = (state == S_READ) && voice_busy[vidx];
  assign rd_addr = MEM_AW'(32'(voice_sound[vidx]) * SOUND_DEPTH
                   + 32'(voice_position[vidx]));

  always_ff @(posedge clk) begin
    if (load_en) begin
      sample_store[wr_addr] <= cmd.sample_word;
    end
    if (rd_en) begin
      rd_data <= sample_store[rd_addr];
    end
  end

  // first idle voice, else voice zero
  always_comb begin
    logic found;
    found = 1'b0;
    slot  = '0;
    for (int v = 0; v < VOICE_COUNT; v++) begin
      if (!found && !voice_busy[v]) begin
        slot  = VID_W'(v);
        found = 1'b1;
      end
    end
  end

  // live length of the current voice's sound
  always_comb begin
    if (32'(voice_sound[vidx]) == 32'(REG_LEN_A)) begin
      raw_len = length_a;
    end else if (32'(voice_sound[vidx]) == 32'(REG_LEN_B)) begin
      raw_len = length_b;
    end else if (32'(voice_sound[vidx]) == 32'(REG_LEN_C)) begin
      raw_len = length_c;
    end else begin
      raw_len = '0;
    end
    cur_len = (32'(raw_len) > SOUND_DEPTH) ? POS_W'(SOUND_DEPTH) : POS_W'(raw_len);
  end

  assign pos_inc = voice_position[vidx] + POS_W'(1);

  // one gain digit per cycle, most significant first
  assign digit     = gain_sr[GAIN_SR_W-1 -: DIGIT_W];
  assign part      = $signed(rd_data) * $signed({1'b0, digit});
  assign prod_next = (prod <<< DIGIT_W) + PROD_W'(part);

  // floor shift and saturation
  always_comb begin
    shifted = acc >>> GAIN_SHIFT;
    if (shifted > SAT_HI) begin
      sat = SAMPLE_W'(SAT_HI);
    end else if (shifted < SAT_LO) begin
      sat = SAMPLE_W'(SAT_LO);
    end else begin
      sat = SAMPLE_W'(shifted);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && cmd.opcode == OP_FRAME) begin
          state_next = (frame_in_block == '0) ? S_START : S_READ;
        end
      end
      S_START: begin
        if (sidx == SID_W'(SOUND_COUNT - 1)) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (voice_busy[vidx]) begin
          state_next = S_MUL;
        end else if (last_voice) begin
          state_next = S_OUT;
        end
      end
      S_MUL: begin
        if (dcnt == DCNT_W'(GAIN_DIGITS - 1)) begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        state_next = last_voice ? S_OUT : S_READ;
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      voice_busy     <= '{default: 1'b0};
      voice_sound    <= '{default: '0};
      voice_position <= '{default: '0};
      pending_flags  <= '0;
      frame_in_block <= '0;
      length_a       <= '0;
      length_b       <= '0;
      length_c       <= '0;
      voice_gain     <= GAIN_RESET;
      mix_valid      <= 1'b0;
      sidx           <= '0;
      vidx           <= '0;
      dcnt           <= '0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        case (reg_idx_t'(paddr[CFG_AW-1:2]))
          REG_LEN_A: length_a   <= pwdata[LENGTH_W-1:0];
          REG_LEN_B: length_b   <= pwdata[LENGTH_W-1:0];
          REG_LEN_C: length_c   <= pwdata[LENGTH_W-1:0];
          REG_GAIN:  voice_gain <= pwdata[GAIN_W-1:0];
          default: ;
        endcase
      end

      if (state == S_OUT && out_free) begin
        mix_valid <= 1'b1;
      end else if (mix_ready) begin
        mix_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd.opcode == OP_TRIGGER && cmd_sid_ok) begin
              pending_flags[SID_W'(cmd.snd_sel)] <= 1'b1;
            end
            if (cmd.opcode == OP_FRAME) begin
              acc  <= '0;
              sidx <= '0;
              vidx <= '0;
            end
          end
        end
        S_START: begin
          if (pending_flags[sidx]) begin
            pending_flags[sidx]  <= 1'b0;
            voice_sound[slot]    <= sidx;
            voice_position[slot] <= '0;
            voice_busy[slot]     <= 1'b1;
          end
          sidx <= sidx + SID_W'(1);
        end
        S_READ: begin
          gain_sr <= GAIN_SR_W'(voice_gain);
          prod    <= '0;
          dcnt    <= '0;
          if (!voice_busy[vidx] && !last_voice) begin
            vidx <= vidx + VID_W'(1);
          end
        end
        S_MUL: begin
          prod    <= prod_next;
          gain_sr <= gain_sr << DIGIT_W;
          dcnt    <= dcnt + DCNT_W'(1);
        end
        S_ACC: begin
          acc                  <= acc + ACC_W'(prod);
          voice_position[vidx] <= pos_inc;
          if (pos_inc >= cur_len) begin
            voice_busy[vidx] <= 1'b0;
          end
          if (!last_voice) begin
            vidx <= vidx + VID_W'(1);
          end
        end
        S_OUT: begin
          if (out_free) begin
            mix.mixed_sample <= sat;
            mix.block_end    <= last_frame;
            frame_in_block   <= last_frame ? '0 : frame_in_block + FR_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[CFG_AW-1:2]))
      REG_LEN_A: prdata = CFG_DW'(length_a);
      REG_LEN_B: prdata = CFG_DW'(length_b);
      REG_LEN_C: prdata = CFG_DW'(length_c);
      REG_GAIN:  prdata = CFG_DW'(voice_gain);
      default:   prdata = '0;
    endcase
  end

endmodule
